@@ src/sbct_pkg.sv @@
package sbct_pkg;

  localparam int unsigned QuoBits      = 17;
  localparam int unsigned RemBits      = 25;
  localparam int unsigned DenBits      = 24;
  localparam int unsigned DistBits     = 35;
  localparam int unsigned StepsPerStage = 3;
  localparam int unsigned NumDivStages  = (QuoBits + StepsPerStage - 1) / StepsPerStage;
  localparam int unsigned NumAxes       = 3;
  localparam int unsigned NumDivs       = 2 * NumAxes;

  localparam logic [15:0]        CubeEdgeReset = 16'd256;
  localparam logic signed [17:0] TimeNeg = -18'sd1;
  localparam logic signed [17:0] TimeBig = 18'sd65537;
  localparam logic signed [17:0] TimeOne = 18'sd65536;
  localparam logic signed [1:0]  NormPos = 2'sb01;
  localparam logic signed [1:0]  NormNeg = 2'sb11;

  // one quotient in flight
  typedef struct packed {
    logic [RemBits-1:0]    rem;
    logic [QuoBits-1:0]    quo;
    logic [DenBits-1:0]    den;
    logic                  neg;
    logic                  big;
    logic                  fixed;
    logic signed [17:0]    fval;
  } div_t;

  // payload between stages: entry/exit per axis, then speed signs
  typedef struct packed {
    div_t [NumDivs-1:0]    dv;
    logic [NumAxes-1:0]    sneg;
  } pipe_t;

  // time clamped to the range that decides hit and ordering
  function automatic logic signed [17:0] time_of(input div_t d);
    logic signed [17:0] t;
    if (d.fixed) t = d.fval;
    else if (d.big) t = d.neg ? TimeNeg : TimeBig;
    else if (d.neg && (d.quo != '0)) t = TimeNeg;
    else t = $signed({1'b0, d.quo});
    return t;
  endfunction

endpackage

@@ src/sbct_if.sv @@
interface sbct_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mover_x, mover_y, mover_z;
  logic [15:0]        extent_x, extent_y, extent_z;
  logic signed [23:0] speed_x, speed_y, speed_z;
  logic signed [31:0] cube_x, cube_y, cube_z;
  modport source (output valid, mover_x, mover_y, mover_z, extent_x, extent_y, extent_z,
                  speed_x, speed_y, speed_z, cube_x, cube_y, cube_z, input ready);
  modport sink (input valid, mover_x, mover_y, mover_z, extent_x, extent_y, extent_z,
                speed_x, speed_y, speed_z, cube_x, cube_y, cube_z, output ready);
endinterface

interface sbct_out_if;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [16:0]       entry_time;
  logic signed [1:0] normal_x, normal_y, normal_z;
  modport source (output valid, hit, entry_time, normal_x, normal_y, normal_z, input ready);
  modport sink (input valid, hit, entry_time, normal_x, normal_y, normal_z, output ready);
endinterface

interface sbct_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ src/sbct_front.sv @@
module sbct_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        edge_i,
  sbct_in_if.sink            in_i,
  output logic               valid_o,
  input  logic               ready_i,
  output sbct_pkg::pipe_t    data_o
);
  import sbct_pkg::*;

  logic  valid_q;
  pipe_t data_q, data_d;

  assign in_i.ready = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign data_o     = data_q;

  // distances, magnitudes and overrides per axis
  always_comb begin
    logic signed [DistBits-1:0] pos [NumAxes];
    logic signed [DistBits-1:0] ext [NumAxes];
    logic signed [DistBits-1:0] cps [NumAxes];
    logic signed [23:0]         spd [NumAxes];
    logic signed [DistBits-1:0] ed, de, dx, dd;
    logic [DistBits-1:0]        mag;
    logic [DenBits-1:0]         den;
    int                         k;
    pos[0] = DistBits'(in_i.mover_x); pos[1] = DistBits'(in_i.mover_y);
    pos[2] = DistBits'(in_i.mover_z);
    ext[0] = $signed(DistBits'(in_i.extent_x)); ext[1] = $signed(DistBits'(in_i.extent_y));
    ext[2] = $signed(DistBits'(in_i.extent_z));
    cps[0] = DistBits'(in_i.cube_x); cps[1] = DistBits'(in_i.cube_y);
    cps[2] = DistBits'(in_i.cube_z);
    spd[0] = in_i.speed_x; spd[1] = in_i.speed_y; spd[2] = in_i.speed_z;
    ed = $signed(DistBits'(edge_i));
    data_d = '0;
    for (int a = 0; a < NumAxes; a++) begin
      if (!spd[a][23]) begin
        de = cps[a] - (pos[a] + ext[a]);
        dx = (cps[a] + ed) - pos[a];
      end else begin
        de = (cps[a] + ed) - pos[a];
        dx = cps[a] - (pos[a] + ext[a]);
      end
      den = spd[a][23] ? DenBits'(-$signed({spd[a][23], spd[a]})) : DenBits'(spd[a]);
      data_d.sneg[a] = spd[a][23];
      for (int w = 0; w < 2; w++) begin
        k  = 2 * a + w;
        dd = (w == 0) ? de : dx;
        mag = dd[DistBits-1] ? DistBits'(-dd) : DistBits'(dd);
        data_d.dv[k].rem   = mag[RemBits-1:0];
        data_d.dv[k].quo   = '0;
        data_d.dv[k].den   = den;
        data_d.dv[k].neg   = dd[DistBits-1] ^ spd[a][23];
        data_d.dv[k].big   = mag >= {{(DistBits-DenBits-1){1'b0}}, den, 1'b0};
        data_d.dv[k].fixed = (spd[a] == '0);
        if (w == 0) data_d.dv[k].fval = dd[DistBits-1] ? TimeNeg : TimeBig;
        else        data_d.dv[k].fval = (!dd[DistBits-1] && dd != '0) ? TimeBig : TimeNeg;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      data_q <= data_d;
    end
  end

endmodule

@@ src/sbct_div_stage.sv @@
module sbct_div_stage #(
  parameter int unsigned FirstStep = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  sbct_pkg::pipe_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output sbct_pkg::pipe_t data_o
);
  import sbct_pkg::*;

  logic  valid_q;
  pipe_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // restoring quotient steps, one bit each
  always_comb begin
    logic [RemBits-1:0] r;
    logic               ge;
    data_d = data_i;
    for (int k = 0; k < NumDivs; k++) begin
      for (int t = 0; t < StepsPerStage; t++) begin
        if (FirstStep + t < QuoBits) begin
          r = data_d.dv[k].rem;
          if (FirstStep + t != 0) r = {r[RemBits-2:0], 1'b0};
          ge = r >= {1'b0, data_d.dv[k].den};
          if (ge) r = r - {1'b0, data_d.dv[k].den};
          data_d.dv[k].rem = r;
          data_d.dv[k].quo = {data_d.dv[k].quo[QuoBits-2:0], ge};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

@@ src/sbct_resolve.sv @@
module sbct_resolve (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  sbct_pkg::pipe_t data_i,
  sbct_out_if.source      out_o
);
  import sbct_pkg::*;

  logic              valid_q;
  logic              hit_q, hit_d;
  logic [16:0]       time_q, time_d;
  logic signed [1:0] nrm_q [NumAxes];
  logic signed [1:0] nrm_d [NumAxes];

  assign ready_o          = !valid_q || out_o.ready;
  assign out_o.valid      = valid_q;
  assign out_o.hit        = hit_q;
  assign out_o.entry_time = time_q;
  assign out_o.normal_x   = nrm_q[0];
  assign out_o.normal_y   = nrm_q[1];
  assign out_o.normal_z   = nrm_q[2];

  // latest entry, earliest exit, hit test and face pick
  always_comb begin
    logic signed [17:0] en [NumAxes];
    logic signed [17:0] ex [NumAxes];
    logic signed [17:0] maxe, minx;
    for (int a = 0; a < NumAxes; a++) begin
      en[a] = time_of(data_i.dv[2*a]);
      ex[a] = time_of(data_i.dv[2*a+1]);
    end
    maxe = en[0];
    if (en[1] > maxe) maxe = en[1];
    if (en[2] > maxe) maxe = en[2];
    minx = ex[0];
    if (ex[1] < minx) minx = ex[1];
    if (ex[2] < minx) minx = ex[2];
    hit_d  = !(maxe > minx) && (maxe >= 0) && (maxe <= TimeOne);
    time_d = hit_d ? maxe[16:0] : '0;
    for (int a = 0; a < NumAxes; a++) nrm_d[a] = '0;
    if (hit_d) begin
      if (maxe == en[0])      nrm_d[0] = data_i.sneg[0] ? NormPos : NormNeg;
      else if (maxe == en[1]) nrm_d[1] = data_i.sneg[1] ? NormPos : NormNeg;
      else                    nrm_d[2] = data_i.sneg[2] ? NormPos : NormNeg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      hit_q  <= hit_d;
      time_q <= time_d;
      nrm_q  <= nrm_d;
    end
  end

endmodule

@@ src/swept_box_collision_test.sv @@
// Channel | Dir | Contents
// in_i    | in  | moving box corner, extent, speed; cube corner
// out_o   | out | hit, entry_time, normal_x/y/z
// cfg_i   | in  | cube_edge (Q8.8)
//
// One request per cycle while the output is not stalled; the stages are setup, six divider
// stages and resolve. The 17-bit quotient, three bits per stage, sets the depth.
// Reset clears all valid bits and loads cube_edge with one block.
// Each stage holds its request while the next one is full and stalled.
module swept_box_collision_test (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbct_in_if.sink    in_i,
  sbct_cfg_if.sink   cfg_i,
  sbct_out_if.source out_o
);
  import sbct_pkg::*;

  logic [15:0] edge_q;
  logic        vld [NumDivStages+1];
  logic        rdy [NumDivStages+1];
  pipe_t       dat [NumDivStages+1];

  // cube edge register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q <= CubeEdgeReset;
    end else if (cfg_i.valid) begin
      edge_q <= cfg_i.data;
    end
  end

  sbct_front u_front (
    .clk_i, .rst_ni, .edge_i(edge_q), .in_i,
    .valid_o(vld[0]), .ready_i(rdy[0]), .data_o(dat[0])
  );

  for (genvar s = 0; s < NumDivStages; s++) begin : g_div
    sbct_div_stage #(.FirstStep(s * StepsPerStage)) u_div (
      .clk_i, .rst_ni,
      .valid_i(vld[s]), .ready_o(rdy[s]), .data_i(dat[s]),
      .valid_o(vld[s+1]), .ready_i(rdy[s+1]), .data_o(dat[s+1])
    );
  end

  sbct_resolve u_resolve (
    .clk_i, .rst_ni,
    .valid_i(vld[NumDivStages]), .ready_o(rdy[NumDivStages]), .data_i(dat[NumDivStages]),
    .out_o
  );

endmodule

@@ src/sbct_checker.sv @@
module sbct_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              hit_i,
  input logic [16:0]       entry_time_i,
  input logic signed [1:0] normal_x_i,
  input logic signed [1:0] normal_y_i,
  input logic signed [1:0] normal_z_i
);

  // a miss carries no time and no normal
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !hit_i |-> entry_time_i == '0 && normal_x_i == '0
      && normal_y_i == '0 && normal_z_i == '0)
    else $error("miss with nonzero fields");

  // a hit names exactly one face
  a_hit_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hit_i |-> $onehot({normal_x_i != '0, normal_y_i != '0, normal_z_i != '0}))
    else $error("hit without a single face normal");

  // entry time never passes one tick
  a_hit_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hit_i |-> entry_time_i <= 17'd65536)
    else $error("entry time beyond one tick");

  // stalled result keeps valid, hit and entry time
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(hit_i) && $stable(entry_time_i))
    else $error("stalled result changed");

endmodule

bind swept_box_collision_test sbct_checker u_sbct_checker (
  .clk_i, .rst_ni,
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready), .hit_i(out_o.hit),
  .entry_time_i(out_o.entry_time), .normal_x_i(out_o.normal_x),
  .normal_y_i(out_o.normal_y), .normal_z_i(out_o.normal_z)
);

@@ bench/swept_box_collision_checker.sv @@
module swept_box_collision_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  sbct_in_if.sink   in_i,
  sbct_cfg_if.sink  cfg_i,
  sbct_out_if.sink  out_i,
  output int        errors_o,
  output int        pending_o,
  output int        hits_o,
  output int        results_o
);
  import sbct_pkg::*;

  localparam longint TimeInf = 64'sd1 <<< 62;

  typedef struct packed {
    logic              hit;
    logic [16:0]       entry_time;
    logic signed [1:0] normal_x;
    logic signed [1:0] normal_y;
    logic signed [1:0] normal_z;
  } sweep_res_t;

  sweep_res_t expected_sweeps[$];
  logic [15:0] edge_len;

  // entry and exit times along one axis
  function automatic void axis_span(input longint pos, input longint ext, input longint spd,
                                    input longint cpos, input longint len,
                                    output longint t_in, output longint t_out);
    longint d_in, d_out;
    if (spd >= 0) begin
      d_in  = cpos - (pos + ext);
      d_out = (cpos + len) - pos;
    end else begin
      d_in  = (cpos + len) - pos;
      d_out = cpos - (pos + ext);
    end
    if (spd == 0) begin
      t_in  = (d_in < 0) ? -TimeInf : TimeInf;
      t_out = (d_out > 0) ? TimeInf : -TimeInf;
    end else begin
      // SV division truncates toward zero
      t_in  = (d_in * 65536) / spd;
      t_out = (d_out * 65536) / spd;
    end
  endfunction

  function automatic sweep_res_t sweep_test(input longint pos[3], input longint ext[3],
                                            input longint spd[3], input longint cpos[3],
                                            input logic [15:0] len);
    sweep_res_t r;
    longint t_in[3], t_out[3];
    longint latest, earliest;
    int ax;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      axis_span(pos[i], ext[i], spd[i], cpos[i], longint'(len), t_in[i], t_out[i]);
    end
    latest = t_in[0];
    if (t_in[1] > latest) latest = t_in[1];
    if (t_in[2] > latest) latest = t_in[2];
    earliest = t_out[0];
    if (t_out[1] < earliest) earliest = t_out[1];
    if (t_out[2] < earliest) earliest = t_out[2];
    if (latest > earliest || latest < 0 || latest > 65536) return r;
    // ties go to the lower axis
    if (latest == t_in[0]) ax = 0;
    else if (latest == t_in[1]) ax = 1;
    else ax = 2;
    r.hit = 1'b1;
    r.entry_time = latest[16:0];
    case (ax)
      0: r.normal_x = (spd[0] < 0) ? NormPos : NormNeg;
      1: r.normal_y = (spd[1] < 0) ? NormPos : NormNeg;
      default: r.normal_z = (spd[2] < 0) ? NormPos : NormNeg;
    endcase
    return r;
  endfunction

  // predict on accepted requests, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    longint pos[3], ext[3], spd[3], cpos[3];
    sweep_res_t want, got;
    if (!rst_ni) begin
      edge_len = CubeEdgeReset;
      expected_sweeps.delete();
      errors_o <= 0;
      hits_o <= 0;
      results_o <= 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        pos[0] = in_i.mover_x; pos[1] = in_i.mover_y; pos[2] = in_i.mover_z;
        ext[0] = in_i.extent_x; ext[1] = in_i.extent_y; ext[2] = in_i.extent_z;
        spd[0] = in_i.speed_x; spd[1] = in_i.speed_y; spd[2] = in_i.speed_z;
        cpos[0] = in_i.cube_x; cpos[1] = in_i.cube_y; cpos[2] = in_i.cube_z;
        expected_sweeps.push_back(sweep_test(pos, ext, spd, cpos, edge_len));
      end
      if (cfg_i.valid && cfg_i.ready) edge_len = cfg_i.data;
      if (out_i.valid && out_i.ready) begin
        got = '{out_i.hit, out_i.entry_time, out_i.normal_x, out_i.normal_y, out_i.normal_z};
        results_o <= results_o + 1;
        if (got.hit) hits_o <= hits_o + 1;
        if (expected_sweeps.size() == 0) begin
          $error("result with no request outstanding");
          errors_o <= errors_o + 1;
        end else begin
          want = expected_sweeps.pop_front();
          if (got != want) begin
            errors_o <= errors_o + 1;
            if (got.hit != want.hit)
              $error("hit: expected %0d, got %0d", want.hit, got.hit);
            if (got.entry_time != want.entry_time)
              $error("entry_time: expected %0d, got %0d", want.entry_time, got.entry_time);
            if (got.normal_x != want.normal_x)
              $error("normal_x: expected %0d, got %0d", want.normal_x, got.normal_x);
            if (got.normal_y != want.normal_y)
              $error("normal_y: expected %0d, got %0d", want.normal_y, got.normal_y);
            if (got.normal_z != want.normal_z)
              $error("normal_z: expected %0d, got %0d", want.normal_z, got.normal_z);
          end
        end
      end
    end
  end

  assign pending_o = expected_sweeps.size();

endmodule

@@ bench/swept_box_collision_test_tb.sv @@
module swept_box_collision_test_tb;
  import sbct_pkg::*;

  localparam int RandomSweeps = 1900;
  localparam int CycleLimit   = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending, hits, results;
  int   cycles = 0;
  logic hold_off = 1'b0;
  logic stall_on = 1'b0;
  int   sent = 0;

  sbct_in_if  in_ch ();
  sbct_cfg_if cfg_ch ();
  sbct_out_if out_ch ();

  swept_box_collision_test dut (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_i (in_ch), .cfg_i (cfg_ch), .out_o (out_ch)
  );

  swept_box_collision_checker checker_inst (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_i (in_ch), .cfg_i (cfg_ch), .out_i (out_ch),
    .errors_o (errors), .pending_o (pending), .hits_o (hits), .results_o (results)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stall pattern, plus a long hold-off
  always @(posedge clk_i) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else if (stall_on) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= 1'b1;
  end

  // long receiver hold-off partway through the third random phase
  initial begin
    wait (sent >= 824);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // set up the fields of one request (no handshake)
  task automatic load_sweep(input logic [31:0] mx, my, mz, input logic [15:0] ex, ey, ez,
                            input logic [23:0] sx, sy, sz, input logic [31:0] cx, cy, cz);
    in_ch.mover_x <= mx; in_ch.mover_y <= my; in_ch.mover_z <= mz;
    in_ch.extent_x <= ex; in_ch.extent_y <= ey; in_ch.extent_z <= ez;
    in_ch.speed_x <= sx; in_ch.speed_y <= sy; in_ch.speed_z <= sz;
    in_ch.cube_x <= cx; in_ch.cube_y <= cy; in_ch.cube_z <= cz;
  endtask

  // offer one request and wait for acceptance; valid stays high for the next
  task automatic send_sweep(input logic [31:0] mx, my, mz, input logic [15:0] ex, ey, ez,
                            input logic [23:0] sx, sy, sz, input logic [31:0] cx, cy, cz);
    load_sweep(mx, my, mz, ex, ey, ez, sx, sy, sz, cx, cy, cz);
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
  endtask

  task automatic idle_input(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic write_edge(input logic [15:0] len);
    cfg_ch.data <= len;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [31:0] near(input logic [31:0] base, input int span);
    return base + $urandom_range(0, 2 * span) - span;
  endfunction

  // random sweep: mostly near-contact geometry, some fully random
  task automatic random_sweep();
    logic [31:0] cx, cy, cz;
    logic [15:0] ex, ey, ez;
    logic [23:0] sx, sy, sz;
    int mode;
    mode = $urandom_range(0, 9);
    cx = $urandom; cy = $urandom; cz = $urandom;
    if (mode == 0) begin
      send_sweep($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                 24'($urandom), 24'($urandom), 24'($urandom), cx, cy, cz);
    end else begin
      ex = 16'($urandom_range(0, 1023)); ey = 16'($urandom_range(0, 1023));
      ez = 16'($urandom_range(0, 1023));
      if (mode == 1) ex = 16'($urandom);
      sx = 24'($signed(11'($urandom))); sy = 24'($signed(11'($urandom)));
      sz = 24'($signed(11'($urandom)));
      if (mode == 2) sx = '0;
      if (mode == 3) begin sy = '0; sz = '0; end
      if (mode == 4) sz = 24'($urandom);
      send_sweep(near(cx, 800), near(cy, 800), near(cz, 800), ex, ey, ez, sx, sy, sz,
                 cx, cy, cz);
    end
  endtask

  initial begin
    logic [15:0] edges[5];
    edges = '{16'd0, 16'd65535, 16'd1, 16'd512, 16'd256};
    in_ch.valid = 1'b0;
    {in_ch.mover_x, in_ch.mover_y, in_ch.mover_z} = '0;
    {in_ch.extent_x, in_ch.extent_y, in_ch.extent_z} = '0;
    {in_ch.speed_x, in_ch.speed_y, in_ch.speed_z} = '0;
    {in_ch.cube_x, in_ch.cube_y, in_ch.cube_z} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed cases at reset edge: head-on on each axis, miss, zero speed, extremes
    send_sweep(-32'sd512, 0, 0, 256, 256, 256, 24'sd512, 0, 0, 0, 0, 0);
    send_sweep(32'sd512, 0, 0, 256, 256, 256, -24'sd512, 0, 0, 0, 0, 0);
    send_sweep(0, -32'sd512, 0, 256, 256, 256, 0, 24'sd512, 0, 0, 0, 0);
    send_sweep(0, 0, 32'sd512, 256, 256, 256, 0, 0, -24'sd512, 0, 0, 0);
    send_sweep(-32'sd256, -32'sd256, -32'sd256, 256, 256, 256, 256, 256, 256, 0, 0, 0);
    send_sweep(0, 0, 0, 256, 256, 256, 0, 0, 0, 0, 0, 0);
    send_sweep(-32'sd300, 0, 0, 256, 256, 256, 24'sd44, 0, 0, 0, 0, 0);
    send_sweep(-32'sd256, 0, 0, 256, 256, 256, 24'sd1, 0, 0, 0, 0, 0);
    send_sweep(-32'sd100, 0, 0, 256, 256, 256, 24'sd100, 0, 0, 0, 0, 0);
    send_sweep(-32'sd1, 0, 0, 256, 256, 256, -24'sd3, 0, 0, 0, 0, 0);
    send_sweep(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'hffff, 16'hffff, 16'hffff,
               24'h7fffff, 24'h800000, 24'h7fffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_sweep(32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0,
               24'h800000, 24'h7fffff, 24'h800000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_sweep(-32'sd1000, 0, 0, 0, 0, 0, 24'h7fffff, 0, 0, 0, 0, 0);
    send_sweep(0, 0, 0, 256, 256, 256, 24'sd7, 0, 0, 0, 0, 0);
    drain();

    // random phases across cube edge settings, with bursts and gaps
    stall_on = 1'b1;
    for (int p = 0; p < 5; p++) begin
      write_edge(edges[p]);
      for (int k = 0; k < RandomSweeps / 5; k++) begin
        random_sweep();
        if ($urandom_range(0, 7) == 0) idle_input($urandom_range(1, 6));
        if (p == 3) stall_on = (k % 200) < 100;
      end
      drain();
    end

    $display("Sent %0d sweeps, %0d results checked, %0d hits; cube edge swept over 0..65535.",
             sent, results, hits);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
src/sbct_pkg.sv
src/sbct_if.sv
src/sbct_front.sv
src/sbct_div_stage.sv
src/sbct_resolve.sv
src/swept_box_collision_test.sv
src/sbct_checker.sv
bench/swept_box_collision_checker.sv
bench/swept_box_collision_test_tb.sv
